### src/soe_pkg.sv
// soe_pkg: shared types, word constants and the microcode program for the
// second-order low-pass filter. No dependencies.

package soe_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int ADDR_BITS = 4;
    localparam int PROG_LEN  = 17;
    localparam int PC_BITS   = $clog2(PROG_LEN);

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_FREQ = 2'd0,
        REG_DAMP = 2'd1,
        REG_GAIN = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MUL,
        OP_ADD,
        OP_SUB
    } op_t;

    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_NF,
        SRC_DR,
        SRC_G,
        SRC_SPK,
        SRC_DT,
        SRC_II,
        SRC_PI,
        SRC_VI,
        SRC_POS,
        SRC_VEL,
        SRC_W2,
        SRC_ZW,
        SRC_T,
        SRC_A,
        SRC_P
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_II,
        DST_PI,
        DST_VI,
        DST_POS,
        DST_VEL,
        DST_W2,
        DST_ZW,
        DST_T,
        DST_A,
        DST_X
    } dst_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT,
        JMP_ZERO
    } jmp_t;

    // one control word: alu/multiplier op with operands, alu destination,
    // destination for the saturated product, and the sequencing action
    typedef struct packed {
        op_t  op;
        src_t a_sel;
        src_t b_sel;
        dst_t dst;
        dst_t pdst;
        jmp_t jmp;
    } ctrl_t;

    function automatic ctrl_t cw(op_t op, src_t a, src_t b, dst_t d, dst_t pd, jmp_t j);
        ctrl_t c;
        c.op    = op;
        c.a_sel = a;
        c.b_sel = b;
        c.dst   = d;
        c.pdst  = pd;
        c.jmp   = j;
        return c;
    endfunction

    // source P is the saturated value of the last product
    function automatic ctrl_t ucode(logic [PC_BITS-1:0] pc);
        ctrl_t c;
        case (pc)
            5'd0:    c = cw(OP_NOP, SRC_NONE, SRC_NONE, DST_NONE, DST_NONE, JMP_WAIT);
            5'd1:    c = cw(OP_MUL, SRC_NF,   SRC_NF,   DST_NONE, DST_NONE, JMP_NEXT);
            5'd2:    c = cw(OP_ADD, SRC_DR,   SRC_DR,   DST_T,    DST_W2,   JMP_NEXT);
            5'd3:    c = cw(OP_MUL, SRC_T,    SRC_NF,   DST_NONE, DST_NONE, JMP_NEXT);
            5'd4:    c = cw(OP_MUL, SRC_SPK,  SRC_DT,   DST_NONE, DST_ZW,   JMP_NEXT);
            5'd5:    c = cw(OP_ADD, SRC_II,   SRC_P,    DST_II,   DST_NONE, JMP_NEXT);
            5'd6:    c = cw(OP_MUL, SRC_II,   SRC_G,    DST_NONE, DST_NONE, JMP_NEXT);
            5'd7:    c = cw(OP_MUL, SRC_P,    SRC_W2,   DST_NONE, DST_NONE, JMP_NEXT);
            5'd8:    c = cw(OP_MUL, SRC_POS,  SRC_DT,   DST_NONE, DST_X,    JMP_NEXT);
            5'd9:    c = cw(OP_ADD, SRC_PI,   SRC_P,    DST_PI,   DST_NONE, JMP_NEXT);
            5'd10:   c = cw(OP_MUL, SRC_PI,   SRC_W2,   DST_NONE, DST_NONE, JMP_NEXT);
            5'd11:   c = cw(OP_MUL, SRC_VEL,  SRC_DT,   DST_NONE, DST_A,    JMP_NEXT);
            5'd12:   c = cw(OP_ADD, SRC_VI,   SRC_P,    DST_VI,   DST_T,    JMP_NEXT);
            5'd13:   c = cw(OP_MUL, SRC_VI,   SRC_ZW,   DST_NONE, DST_NONE, JMP_NEXT);
            5'd14:   c = cw(OP_ADD, SRC_POS,  SRC_T,    DST_POS,  DST_NONE, JMP_NEXT);
            5'd15:   c = cw(OP_SUB, SRC_NONE, SRC_A,    DST_X,    DST_NONE, JMP_NEXT);
            5'd16:   c = cw(OP_SUB, SRC_NONE, SRC_P,    DST_VEL,  DST_NONE, JMP_ZERO);
            default: c = cw(OP_NOP, SRC_NONE, SRC_NONE, DST_NONE, DST_NONE, JMP_ZERO);
        endcase
        return c;
    endfunction

endpackage

### src/soe_cfg.sv
// soe_cfg: apb-style configuration registers (omega, zeta, gain).
// Depends on soe_pkg.

module soe_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [soe_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [30:0]                   natural_freq,
    output logic [30:0]                   damping_ratio,
    output logic signed [31:0]            dc_gain
);

    logic [30:0]        freq_reg, freq_next;
    logic [30:0]        damp_reg, damp_next;
    logic signed [31:0] gain_reg, gain_next;
    logic               wr_en;
    soe_pkg::reg_idx_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = soe_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        freq_next = freq_reg;
        damp_next = damp_reg;
        gain_next = gain_reg;
        if (wr_en)
        begin
            case (idx)
                soe_pkg::REG_FREQ: freq_next = pwdata[30:0];
                soe_pkg::REG_DAMP: damp_next = pwdata[30:0];
                soe_pkg::REG_GAIN: gain_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            soe_pkg::REG_FREQ: prdata = {1'b0, freq_reg};
            soe_pkg::REG_DAMP: prdata = {1'b0, damp_reg};
            soe_pkg::REG_GAIN: prdata = gain_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= 31'd65536;
            damp_reg <= 31'd65536;
            gain_reg <= 32'sd65536;
        end
        else
        begin
            freq_reg <= freq_next;
            damp_reg <= damp_next;
            gain_reg <= gain_next;
        end
    end

    assign natural_freq  = freq_reg;
    assign damping_ratio = damp_reg;
    assign dc_gain       = gain_reg;

endmodule

### src/soe_sequencer.sv
// soe_sequencer: step counter and microcode table lookup with jumps.
// Depends on soe_pkg.

module soe_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output soe_pkg::ctrl_t ctrl,
    output logic           idle
);

    logic [soe_pkg::PC_BITS-1:0] pc_reg, pc_next;

    assign ctrl = soe_pkg::ucode(pc_reg);
    assign idle = (pc_reg == '0);

    always_comb
    begin
        case (ctrl.jmp)
            soe_pkg::JMP_WAIT: pc_next = start ? soe_pkg::PC_BITS'(1) : '0;
            soe_pkg::JMP_ZERO: pc_next = '0;
            default:           pc_next = pc_reg + soe_pkg::PC_BITS'(1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

### src/soe_datapath.sv
// soe_datapath: filter state, temporaries, shared multiplier and saturating alu.
// Driven by control words from soe_sequencer; depends on soe_pkg.

module soe_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  soe_pkg::ctrl_t     ctrl,
    input  logic               accept,
    input  logic signed [31:0] spike_sample,
    input  logic [31:0]        timestamp,
    input  logic [30:0]        natural_freq,
    input  logic [30:0]        damping_ratio,
    input  logic signed [31:0] dc_gain,
    output logic signed [31:0] filtered_value
);

    localparam int W = soe_pkg::WORD_BITS;
    localparam int F = soe_pkg::FRAC_BITS;
    localparam int P = soe_pkg::PROD_BITS;
    localparam int M = P - F;

    typedef logic signed [W-1:0] word_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? soe_pkg::WMIN : soe_pkg::WMAX;
        return s[W-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            return s[W] ? soe_pkg::WMIN : soe_pkg::WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(word_t v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // state
    word_t         ii_reg, ii_next;
    word_t         pi_reg, pi_next;
    word_t         vi_reg, vi_next;
    word_t         pos_reg, pos_next;
    word_t         vel_reg, vel_next;
    logic [31:0]   last_time_reg;
    // temporaries and latched inputs
    word_t         w2_reg, w2_next;
    word_t         zw_reg, zw_next;
    word_t         t_reg, t_next;
    word_t         a_reg, a_next;
    word_t         x_reg, x_next;
    word_t         spk_reg;
    logic [31:0]   dt_reg;
    logic [P-1:0]  prod_reg;
    logic          neg_reg;
    word_t         out_reg;

    word_t         a_val, b_val, alu_val, psat_val;
    logic          b_is_dt, alu_we;
    logic [W-1:0]  mag_a, mag_b;
    logic [M-1:0]  prod_shift;

    // saturated fixed-point value of the last product, truncated toward zero
    always_comb
    begin
        prod_shift = prod_reg[P-1:F];
        if (prod_shift > M'(soe_pkg::WMAX))
            psat_val = neg_reg ? soe_pkg::WMIN : soe_pkg::WMAX;
        else if (neg_reg)
            psat_val = -word_t'(prod_shift[W-1:0]);
        else
            psat_val = prod_shift[W-1:0];
    end

    function automatic word_t pick(soe_pkg::src_t s, word_t ps, word_t nf, word_t dr,
                                   word_t g, word_t spk, word_t dt, word_t ii, word_t pi,
                                   word_t vi, word_t pos, word_t vel, word_t w2,
                                   word_t zw, word_t t, word_t a, word_t x);
        case (s)
            soe_pkg::SRC_NF:  return nf;
            soe_pkg::SRC_DR:  return dr;
            soe_pkg::SRC_G:   return g;
            soe_pkg::SRC_SPK: return spk;
            soe_pkg::SRC_DT:  return dt;
            soe_pkg::SRC_II:  return ii;
            soe_pkg::SRC_PI:  return pi;
            soe_pkg::SRC_VI:  return vi;
            soe_pkg::SRC_POS: return pos;
            soe_pkg::SRC_VEL: return vel;
            soe_pkg::SRC_W2:  return w2;
            soe_pkg::SRC_ZW:  return zw;
            soe_pkg::SRC_T:   return t;
            soe_pkg::SRC_A:   return a;
            soe_pkg::SRC_P:   return ps;
            default:          return x;
        endcase
    endfunction

    // operand a from SRC_NONE reads the x temporary (used by the subtract chain)
    always_comb
    begin
        a_val = pick(ctrl.a_sel, psat_val, {{(W-31){1'b0}}, natural_freq},
                     {{(W-31){1'b0}}, damping_ratio}, W'(dc_gain), spk_reg,
                     W'(dt_reg), ii_reg, pi_reg, vi_reg, pos_reg, vel_reg, w2_reg,
                     zw_reg, t_reg, a_reg, x_reg);
        b_val = pick(ctrl.b_sel, psat_val, {{(W-31){1'b0}}, natural_freq},
                     {{(W-31){1'b0}}, damping_ratio}, W'(dc_gain), spk_reg,
                     W'(dt_reg), ii_reg, pi_reg, vi_reg, pos_reg, vel_reg, w2_reg,
                     zw_reg, t_reg, a_reg, x_reg);
        b_is_dt = (ctrl.b_sel == soe_pkg::SRC_DT);
        // dt is an unsigned magnitude
        mag_a   = mag(a_val);
        mag_b   = b_is_dt ? W'(dt_reg) : mag(b_val);
    end

    always_comb
    begin
        alu_we = 1'b1;
        case (ctrl.op)
            soe_pkg::OP_ADD: alu_val = sat_add(a_val, b_val);
            soe_pkg::OP_SUB: alu_val = sat_sub(a_val, b_val);
            default:
            begin
                alu_val = a_val;
                alu_we  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ii_next  = ii_reg;
        pi_next  = pi_reg;
        vi_next  = vi_reg;
        pos_next = pos_reg;
        vel_next = vel_reg;
        w2_next  = w2_reg;
        zw_next  = zw_reg;
        t_next   = t_reg;
        a_next   = a_reg;
        x_next   = x_reg;
        if (alu_we)
        begin
            case (ctrl.dst)
                soe_pkg::DST_II:  ii_next  = alu_val;
                soe_pkg::DST_PI:  pi_next  = alu_val;
                soe_pkg::DST_VI:  vi_next  = alu_val;
                soe_pkg::DST_POS: pos_next = alu_val;
                soe_pkg::DST_VEL: vel_next = alu_val;
                soe_pkg::DST_W2:  w2_next  = alu_val;
                soe_pkg::DST_ZW:  zw_next  = alu_val;
                soe_pkg::DST_T:   t_next   = alu_val;
                soe_pkg::DST_A:   a_next   = alu_val;
                soe_pkg::DST_X:   x_next   = alu_val;
                default: ;
            endcase
        end
        case (ctrl.pdst)
            soe_pkg::DST_W2: w2_next = psat_val;
            soe_pkg::DST_ZW: zw_next = psat_val;
            soe_pkg::DST_T:  t_next  = psat_val;
            soe_pkg::DST_A:  a_next  = psat_val;
            soe_pkg::DST_X:  x_next  = psat_val;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ii_reg        <= '0;
            pi_reg        <= '0;
            vi_reg        <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            ii_reg  <= ii_next;
            pi_reg  <= pi_next;
            vi_reg  <= vi_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            if (accept)
                last_time_reg <= timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        w2_reg <= w2_next;
        zw_reg <= zw_next;
        t_reg  <= t_next;
        a_reg  <= a_next;
        x_reg  <= x_next;
        if (ctrl.op == soe_pkg::OP_MUL)
        begin
            prod_reg <= P'(mag_a) * P'(mag_b);
            neg_reg  <= a_val[W-1] ^ (b_val[W-1] & ~b_is_dt);
        end
        if (accept)
        begin
            spk_reg <= W'(spike_sample);
            dt_reg  <= timestamp - last_time_reg;
            out_reg <= pos_reg;
        end
    end

    assign filtered_value = out_reg[31:0];

endmodule

### src/second_order_lowpass_euler.sv
// second_order_lowpass_euler: top level of the forward-euler second-order filter.
// Instantiates soe_cfg, soe_sequencer and soe_datapath; depends on soe_pkg.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    spike_sample, timestamp
//  out      output     out_valid / out_stall  filtered_value
//  cfg      input      apb psel/penable       paddr, pwdata, prdata
//
// an item runs one idle step plus a 16-step microprogram built
// around the single shared 32x32 multiplier (nine products per item)
// the result (previous position) is loaded into the output register at accept
// reset clears the filter state to zero and sets omega, zeta and gain to 1.0
// the next item is taken once the program is back at step zero and the output
// register is empty or being drained in the same cycle

module second_order_lowpass_euler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            spike_sample,
    input  logic [31:0]                   timestamp,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            filtered_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [soe_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               accept;
    logic               idle;
    logic               out_valid_reg, out_valid_next;
    soe_pkg::ctrl_t     ctrl;
    logic [30:0]        natural_freq;
    logic [30:0]        damping_ratio;
    logic signed [31:0] dc_gain;

    assign in_stall = !idle || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;

    soe_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .natural_freq  (natural_freq),
        .damping_ratio (damping_ratio),
        .dc_gain       (dc_gain)
    );

    soe_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ctrl  (ctrl),
        .idle  (idle)
    );

    soe_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .accept         (accept),
        .spike_sample   (spike_sample),
        .timestamp      (timestamp),
        .natural_freq   (natural_freq),
        .damping_ratio  (damping_ratio),
        .dc_gain        (dc_gain),
        .filtered_value (filtered_value)
    );

endmodule

### src/soe_checker.sv
// soe_checker: port-level assertions for second_order_lowpass_euler, and its bind.
// Depends only on the top level's handshake and payload ports.

module soe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [31:0] spike_sample,
    input logic [31:0]        timestamp,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] filtered_value
);

    // the block works one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in progress");

    // every accepted transaction shows its result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after accepted input");

    // a result only appears from an accepted input
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without input");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_value))
        else $error("stalled result changed");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(spike_sample) && $stable(timestamp))
        else $error("stalled input changed");

endmodule

bind second_order_lowpass_euler soe_checker u_soe_checker (.*);
